// File: src/tns_pkg.sv
// ----------------------------------------------------------------------------
// Tone note sequencer package
// Shared types and constants for the note sequencer and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tns_pkg;

  // Item codes carried on the action field.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_STOP  = 2'd3
  } action_t;

  // Sequencer control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DIV
  } state_t;

  // Field widths.
  localparam int FREQ_W  = 14;
  localparam int DUR_W   = 8;
  localparam int ENTRY_W = FREQ_W + DUR_W;
  localparam int BYTE_W  = 8;
  localparam int VOL_W   = 4;

  // Tone divider: floor(CLOCK_HZ / (32 * f)) equals floor(floor(CLOCK_HZ / 32) / f).
  localparam int unsigned CLOCK_HZ = 3579545;
  localparam int DIV_W     = 10;
  localparam int DIV_STEPS = DIV_W;
  localparam int NUM_W     = 17;
  localparam int REM_W     = FREQ_W + 1;
  localparam logic [NUM_W-1:0] DIV_NUM  = NUM_W'(CLOCK_HZ / 32);
  localparam logic [REM_W-1:0] REM_INIT = REM_W'(DIV_NUM >> DIV_W);
  localparam logic [DIV_W-1:0] NUM_LO   = DIV_NUM[DIV_W-1:0];
  localparam logic [DIV_W-1:0] DIV_MAX  = 10'd1023;
  // At or below this frequency the quotient exceeds DIV_MAX and is clamped.
  localparam logic [FREQ_W-1:0] CLAMP_FREQ = FREQ_W'(DIV_NUM / (1 << DIV_W));

  // Tone chip command bytes.
  localparam logic [BYTE_W-1:0] CMD_SILENCE0 = 8'h9F;
  localparam logic [BYTE_W-1:0] CMD_SILENCE1 = 8'hBF;
  localparam logic [BYTE_W-1:0] CMD_SILENCE2 = 8'hDF;
  localparam logic [BYTE_W-1:0] CMD_SILENCE3 = 8'hFF;
  localparam logic [BYTE_W-1:0] CMD_TONE0    = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_VOL0     = 8'h90;
  localparam logic [BYTE_W-1:0] HI_MASK      = 8'h3F;

  // Result of the serial divider.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_res_t;

endpackage

`default_nettype wire

// File: src/tns_song_mem.sv
// ----------------------------------------------------------------------------
// Song memory
// One write port and one registered read port holding frequency and duration.
// ----------------------------------------------------------------------------
`default_nettype none

module tns_song_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [tns_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [tns_pkg::ENTRY_W-1:0] rd_data
);
  import tns_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/tns_div.sv
// ----------------------------------------------------------------------------
// Tone divider
// Restoring bit-serial division of the scaled chip clock by the note frequency.
// ----------------------------------------------------------------------------
`default_nettype none

module tns_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tns_pkg::FREQ_W-1:0] freq,
  output tns_pkg::div_res_t              res
);
  import tns_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [3:0]          step_r, step_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]    num_r, num_nxt;
  logic [DIV_W-1:0]    quot_r, quot_nxt;
  logic [FREQ_W-1:0]   dvsr_r, dvsr_nxt;
  logic [REM_W:0]      trial;
  logic [REM_W:0]      diff;
  logic                ge;

  // One quotient bit per cycle: bring in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, num_r[DIV_W-1]};
    diff     = trial - {2'b00, dvsr_r};
    ge       = (trial >= {2'b00, dvsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    dvsr_nxt = dvsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 4'(DIV_STEPS - 1);
      rem_nxt  = REM_INIT;
      num_nxt  = NUM_LO;
      dvsr_nxt = freq;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      num_nxt  = {num_r[DIV_W-2:0], 1'b0};
      quot_nxt = {quot_r[DIV_W-2:0], ge};
      if (step_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 4'd1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

`default_nettype wire

// File: src/tone_note_sequencer.sv
// ----------------------------------------------------------------------------
// Tone note sequencer
// Plays a song memory of notes as command bytes for a three-voice tone chip.
// ----------------------------------------------------------------------------
// A load beat, a stopped tick or a running tick gives no bytes. A start
// while stopped or a stop while playing puts out the four silence bytes at
// one per cycle while the consumer is ready. A tick on which a note is due
// reads the song memory, and reads it again when an end-of-song entry sends
// play back to entry zero; a silent or clamped note is then ready at once,
// and any other note waits on the bit-serial divider, which makes one
// quotient bit a cycle and raises its done flag with the last bit. The one
// to three bytes then leave at one per cycle while the consumer is ready. A
// new beat is taken once the previous beat's bytes have all moved into the
// output register. The song memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tone_note_sequencer #(
  parameter int SONG_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input items.
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_action,
  input  wire logic [5:0]                  in_entry_index,
  input  wire logic [tns_pkg::FREQ_W-1:0]  in_note_freq,
  input  wire logic [tns_pkg::DUR_W-1:0]   in_note_duration,
  // Command bytes.
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [tns_pkg::BYTE_W-1:0]  out_command_byte,
  output logic                             out_last,
  // Volume register write.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tns_pkg::VOL_W-1:0]   cfg_volume
);
  import tns_pkg::*;

  localparam int AW = $clog2(SONG_DEPTH);
  localparam int IW = AW + 6;

  state_t              state_r, state_nxt;
  logic                playing_r, playing_nxt;
  logic [AW-1:0]       note_index_r, note_index_nxt;
  logic [DUR_W-1:0]    dur_count_r, dur_count_nxt;
  logic                reread_r, reread_nxt;
  logic [VOL_W-1:0]    volume_r, volume_nxt;
  logic [BYTE_W-1:0]   bytes_r [4];
  logic [BYTE_W-1:0]   bytes_nxt [4];
  logic [2:0]          byte_cnt_r, byte_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_fire;
  logic                emit;
  logic [IW-1:0]       idx_wide;
  logic                mem_wr_en;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [ENTRY_W-1:0]  mem_rd_data;
  logic [FREQ_W-1:0]   rd_freq;
  logic [DUR_W-1:0]    rd_dur;
  logic [AW-1:0]       index_inc;
  logic                div_start;
  div_res_t            div_res;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE) && (byte_cnt_r == 3'd0);
  assign cfg_ready = 1'b1;
  assign idx_wide  = {{AW{1'b0}}, in_entry_index};
  assign rd_freq   = mem_rd_data[ENTRY_W-1:DUR_W];
  assign rd_dur    = mem_rd_data[DUR_W-1:0];
  assign index_inc = (note_index_r == AW'(SONG_DEPTH - 1)) ? '0 : note_index_r + 1'b1;
  assign mem_wr_en = in_fire && (in_action == ACT_LOAD) && (idx_wide < IW'(SONG_DEPTH));
  assign emit      = (byte_cnt_r != 3'd0) && (!out_valid_r || out_ready);

  // Song memory.
  tns_song_mem #(
    .DEPTH (SONG_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_wide[AW-1:0]),
    .wr_data ({in_note_freq, in_note_duration}),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Tone divider.
  tns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .freq  (rd_freq),
    .res   (div_res)
  );

  // Next state, byte queue and output register.
  always_comb begin
    state_nxt      = state_r;
    playing_nxt    = playing_r;
    note_index_nxt = note_index_r;
    dur_count_nxt  = dur_count_r;
    reread_nxt     = reread_r;
    volume_nxt     = volume_r;
    bytes_nxt      = bytes_r;
    byte_cnt_nxt   = byte_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = note_index_r;
    div_start      = 1'b0;

    // Volume register write.
    if (cfg_valid) begin
      volume_nxt = cfg_volume;
    end

    // Move the head of the byte queue into the output register.
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = bytes_r[0];
      out_last_nxt  = (byte_cnt_r == 3'd1);
      bytes_nxt[0]  = bytes_r[1];
      bytes_nxt[1]  = bytes_r[2];
      bytes_nxt[2]  = bytes_r[3];
      byte_cnt_nxt  = byte_cnt_r - 3'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_START: begin
              if (!playing_r) begin
                bytes_nxt      = '{CMD_SILENCE0, CMD_SILENCE1, CMD_SILENCE2, CMD_SILENCE3};
                byte_cnt_nxt   = 3'd4;
                note_index_nxt = '0;
                dur_count_nxt  = '0;
                playing_nxt    = 1'b1;
              end
            end
            ACT_STOP: begin
              if (playing_r) begin
                bytes_nxt    = '{CMD_SILENCE0, CMD_SILENCE1, CMD_SILENCE2, CMD_SILENCE3};
                byte_cnt_nxt = 3'd4;
                playing_nxt  = 1'b0;
              end
            end
            ACT_TICK: begin
              if (playing_r) begin
                if (dur_count_r == '0) begin
                  mem_rd_en  = 1'b1;
                  reread_nxt = 1'b0;
                  state_nxt  = ST_FETCH;
                end else begin
                  dur_count_nxt = dur_count_r - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_FETCH: begin
        if ((rd_dur == '0) && !reread_r) begin
          // End of song: restart from entry zero.
          mem_rd_en      = 1'b1;
          mem_rd_addr    = '0;
          note_index_nxt = '0;
          reread_nxt     = 1'b1;
        end else begin
          dur_count_nxt  = rd_dur;
          note_index_nxt = index_inc;
          reread_nxt     = 1'b0;
          if (rd_freq == '0) begin
            bytes_nxt[0] = CMD_SILENCE0;
            byte_cnt_nxt = 3'd1;
            state_nxt    = ST_IDLE;
          end else if (rd_freq <= CLAMP_FREQ) begin
            bytes_nxt[0] = CMD_TONE0 | {4'h0, DIV_MAX[3:0]};
            bytes_nxt[1] = HI_MASK & {2'b00, DIV_MAX[DIV_W-1:4]};
            bytes_nxt[2] = CMD_VOL0 | {4'h0, volume_r};
            byte_cnt_nxt = 3'd3;
            state_nxt    = ST_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_res.done) begin
          bytes_nxt[0] = CMD_TONE0 | {4'h0, div_res.quot[3:0]};
          bytes_nxt[1] = HI_MASK & {2'b00, div_res.quot[DIV_W-1:4]};
          bytes_nxt[2] = CMD_VOL0 | {4'h0, volume_r};
          byte_cnt_nxt = 3'd3;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      playing_r    <= 1'b0;
      note_index_r <= '0;
      dur_count_r  <= '0;
      reread_r     <= 1'b0;
      volume_r     <= 4'd2;
      byte_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      playing_r    <= playing_nxt;
      note_index_r <= note_index_nxt;
      dur_count_r  <= dur_count_nxt;
      reread_r     <= reread_nxt;
      volume_r     <= volume_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_command_byte = out_byte_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire
